// ===== sv/cfrp_pkg.sv =====
// Shared types, constants and header lookup functions of the CSI feedback record parser.
// Depends on nothing; cfrp_hdr, cfrp_unpack and the top level import it.
package cfrp_pkg;

	localparam int HDR_BYTES = 34;

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_DONE    = 2'd3;

	localparam logic [3:0] F_RX       = 4'd2;
	localparam logic [3:0] F_TX       = 4'd3;
	localparam logic [3:0] F_PERM     = 4'd9;
	localparam logic [3:0] F_LEN      = 4'd10;
	localparam logic [3:0] F_MAC      = 4'd14;
	localparam logic [3:0] F_NONE     = 4'd15;

	localparam logic [1:0] SKIP_BITS  = 2'd3;

	typedef struct packed {
		logic        emit;
		logic [3:0]  field_id;
		logic [47:0] value;
		logic        err;
		logic        done;
	} hdr_res_t;

	typedef struct packed {
		logic        emit;
		logic [7:0]  csi_real;
		logic [7:0]  csi_imag;
		logic [4:0]  subcarrier;
		logic [3:0]  element_index;
		logic        last;
	} pay_res_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  field_id;
		logic [47:0] value;
		logic [7:0]  csi_real;
		logic [7:0]  csi_imag;
		logic [4:0]  subcarrier;
		logic [3:0]  element_index;
		logic        length_error;
		logic        last;
	} res_t;

	// Header field that a byte position belongs to; bytes 6 and 7 belong to none.
	function automatic logic [3:0] hdr_field(input logic [5:0] pos);
		logic [3:0] f;
		case (pos)
			6'd0, 6'd1, 6'd2, 6'd3:     f = 4'd0;
			6'd4, 6'd5:                 f = 4'd1;
			6'd8:                       f = 4'd2;
			6'd9:                       f = 4'd3;
			6'd10:                      f = 4'd4;
			6'd11:                      f = 4'd5;
			6'd12:                      f = 4'd6;
			6'd13:                      f = 4'd7;
			6'd14:                      f = 4'd8;
			6'd15:                      f = 4'd9;
			6'd16, 6'd17:               f = 4'd10;
			6'd18, 6'd19:               f = 4'd11;
			6'd20, 6'd21, 6'd22, 6'd23: f = 4'd12;
			6'd24, 6'd25, 6'd26, 6'd27: f = 4'd13;
			6'd28, 6'd29, 6'd30, 6'd31,
			6'd32, 6'd33:               f = F_MAC;
			default:                    f = F_NONE;
		endcase
		return f;
	endfunction

	function automatic logic [5:0] hdr_start(input logic [3:0] f);
		logic [5:0] s;
		case (f)
			4'd0:    s = 6'd0;
			4'd1:    s = 6'd4;
			4'd2:    s = 6'd8;
			4'd3:    s = 6'd9;
			4'd4:    s = 6'd10;
			4'd5:    s = 6'd11;
			4'd6:    s = 6'd12;
			4'd7:    s = 6'd13;
			4'd8:    s = 6'd14;
			4'd9:    s = 6'd15;
			4'd10:   s = 6'd16;
			4'd11:   s = 6'd18;
			4'd12:   s = 6'd20;
			4'd13:   s = 6'd24;
			4'd14:   s = 6'd28;
			default: s = 6'd0;
		endcase
		return s;
	endfunction

	function automatic logic [5:0] hdr_end(input logic [3:0] f);
		logic [5:0] e;
		case (f)
			4'd0:    e = 6'd3;
			4'd1:    e = 6'd5;
			4'd2:    e = 6'd8;
			4'd3:    e = 6'd9;
			4'd4:    e = 6'd10;
			4'd5:    e = 6'd11;
			4'd6:    e = 6'd12;
			4'd7:    e = 6'd13;
			4'd8:    e = 6'd14;
			4'd9:    e = 6'd15;
			4'd10:   e = 6'd17;
			4'd11:   e = 6'd19;
			4'd12:   e = 6'd23;
			4'd13:   e = 6'd27;
			4'd14:   e = 6'd33;
			default: e = 6'd63;
		endcase
		return e;
	endfunction

endpackage

// ===== sv/cfrp_byte_if.sv =====
// Byte stream channel into the CSI feedback record parser.
// Depends on nothing.
interface cfrp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source (output valid, output data_byte, output first_byte, input ready);
	modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

// ===== sv/cfrp_res_if.sv =====
// Result channel out of the CSI feedback record parser.
// Depends on nothing.
interface cfrp_res_if;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [3:0]        field_id;
	logic [47:0]       value;
	logic signed [7:0] csi_real;
	logic signed [7:0] csi_imag;
	logic [4:0]        subcarrier;
	logic [3:0]        element_index;
	logic              length_error;
	logic              last;

	modport source (output valid, output kind, output field_id, output value,
		output csi_real, output csi_imag, output subcarrier, output element_index,
		output length_error, output last, input ready);
	modport sink   (input valid, input kind, input field_id, input value,
		input csi_real, input csi_imag, input subcarrier, input element_index,
		input length_error, input last, output ready);
endinterface

// ===== sv/cfrp_hdr.sv =====
// Header decoder: byte position, field assembly, chain counts and the length check.
// Depends on cfrp_pkg.
module cfrp_hdr #(
	parameter int SUBCARRIERS = 30,
	parameter int MAX_CHAINS  = 3,
	parameter int CHW         = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              restart,
	input  logic [7:0]        data_byte,
	output cfrp_pkg::hdr_res_t res,
	output logic [CHW-1:0]    rx,
	output logic [CHW-1:0]    tx
);
	import cfrp_pkg::*;

	localparam int CW = 18;

	logic [5:0]    pos_q;
	logic [47:0]   acc_q;
	logic [7:0]    rx_q;
	logic [7:0]    tx_q;

	logic [5:0]    pos;
	logic [47:0]   acc;
	logic [47:0]   acc_n;
	logic [3:0]    f;
	logic [5:0]    off;
	logic          is_end;
	logic          chains_ok;
	logic [2*CHW-1:0] prod;
	logic [CW-1:0] calc;
	logic          err;
	logic [47:0]   v;

	always_comb begin
		pos = restart ? 6'd0 : pos_q;
		acc = restart ? 48'd0 : acc_q;
		f   = hdr_field(pos);
		off = pos - hdr_start(f);
		if (f == F_MAC) begin
			acc_n = {acc[39:0], data_byte};
		end else begin
			acc_n = acc | (48'(data_byte) << {off[1:0], 3'b000});
		end
		is_end = (f != F_NONE) && (pos == hdr_end(f));

		chains_ok = (rx_q >= 8'd1) && (rx_q <= 8'(MAX_CHAINS)) &&
			(tx_q >= 8'd1) && (tx_q <= 8'(MAX_CHAINS));
		prod = rx_q[CHW-1:0] * tx_q[CHW-1:0];
		calc = (CW'(SUBCARRIERS) * ((CW'(prod) << 4) + CW'(3)) + CW'(7)) >> 3;
		err  = (f == F_LEN) && (!chains_ok || ({2'b00, acc_n[15:0]} != calc));

		v = acc_n;
		if (f == F_PERM) begin
			v = 48'({4'(acc_n[5:4]) + 4'd1, 4'(acc_n[3:2]) + 4'd1, 4'(acc_n[1:0]) + 4'd1});
		end

		res.emit     = is_end;
		res.field_id = f;
		res.value    = v;
		res.err      = is_end && err;
		res.done     = (pos == 6'(HDR_BYTES - 1)) && !(is_end && err);
	end

	assign rx = rx_q[CHW-1:0];
	assign tx = tx_q[CHW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			acc_q <= '0;
			rx_q  <= '0;
			tx_q  <= '0;
		end else if (step) begin
			if (is_end) begin
				acc_q <= '0;
				if (f == F_RX) rx_q <= acc_n[7:0];
				if (f == F_TX) tx_q <= acc_n[7:0];
			end else if (f != F_NONE) begin
				acc_q <= acc_n;
			end else begin
				acc_q <= acc;
			end
			if (!(is_end && err)) begin
				pos_q <= pos + 6'd1;
			end
		end
	end

endmodule

// ===== sv/cfrp_unpack.sv =====
// Payload unpacker: LSB-first bit buffer, per-subcarrier skip and sample counters.
// Depends on cfrp_pkg.
module cfrp_unpack #(
	parameter int SUBCARRIERS = 30,
	parameter int CHW         = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               init,
	input  logic               step,
	input  logic [7:0]         data_byte,
	input  logic [CHW-1:0]     rx,
	input  logic [CHW-1:0]     tx,
	output cfrp_pkg::pay_res_t res
);
	import cfrp_pkg::*;

	localparam int SCW = ($clog2(SUBCARRIERS + 1) > 5) ? $clog2(SUBCARRIERS + 1) : 5;

	logic [23:0]    buf_q;
	logic [4:0]     held_q;
	logic [SCW-1:0] sc_q;
	logic [3:0]     ec_q;
	logic [1:0]     skip_q;

	logic [23:0]    buf1, buf2, buf3, buf4;
	logic [4:0]     held1, held2, held3, held4;
	logic [1:0]     skip2, skip3, skip4;
	logic [4:0]     elems;
	logic [4:0]     ec1;
	logic           wrap;
	logic [SCW-1:0] sc1;
	logic [3:0]     ec_n;
	logic           emit;
	logic           last;

	always_comb begin
		buf1  = buf_q | (24'(data_byte) << held_q);
		held1 = held_q + 5'd8;
		if (skip_q != 2'd0 && held1 >= 5'(skip_q)) begin
			buf2  = buf1 >> skip_q;
			held2 = held1 - 5'(skip_q);
			skip2 = 2'd0;
		end else begin
			buf2  = buf1;
			held2 = held1;
			skip2 = skip_q;
		end
		emit = (skip2 == 2'd0) && (held2 >= 5'd16);

		buf3  = buf2 >> 16;
		held3 = held2 - 5'd16;
		elems = 5'(rx) * 5'(tx);
		ec1   = 5'(ec_q) + 5'd1;
		wrap  = ec1 >= elems;
		sc1   = wrap ? sc_q + SCW'(1) : sc_q;
		ec_n  = wrap ? 4'd0 : ec1[3:0];
		skip3 = wrap ? SKIP_BITS : 2'd0;
		last  = sc1 >= SCW'(SUBCARRIERS);
		if (skip3 != 2'd0 && held3 >= 5'(skip3)) begin
			buf4  = buf3 >> skip3;
			held4 = held3 - 5'(skip3);
			skip4 = 2'd0;
		end else begin
			buf4  = buf3;
			held4 = held3;
			skip4 = skip3;
		end

		res.emit          = emit;
		res.csi_real      = buf2[7:0];
		res.csi_imag      = buf2[15:8];
		res.subcarrier    = sc_q[4:0];
		res.element_index = ec_q;
		res.last          = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			held_q <= '0;
			sc_q   <= '0;
			ec_q   <= '0;
			skip_q <= SKIP_BITS;
		end else if (init) begin
			buf_q  <= '0;
			held_q <= '0;
			sc_q   <= '0;
			ec_q   <= '0;
			skip_q <= SKIP_BITS;
		end else if (step) begin
			if (emit) begin
				buf_q  <= buf4;
				held_q <= held4;
				skip_q <= skip4;
				sc_q   <= sc1;
				ec_q   <= ec_n;
			end else begin
				buf_q  <= buf2;
				held_q <= held2;
				skip_q <= skip2;
			end
		end
	end

endmodule

// ===== sv/csi_feedback_record_parser_unit.sv =====
// Top level of the CSI feedback record parser: input register, record phase, result register.
// Depends on cfrp_pkg, cfrp_byte_if, cfrp_res_if, cfrp_hdr and cfrp_unpack.
//
// Usage: a feedback record enters on the feed channel one byte per transfer, with
// first_byte set on its first byte; a set first_byte always restarts the parser and
// drops whatever was left of the previous record. The 34 header bytes yield fifteen
// header results (kind 0), each on the byte that completes its field. A failed size
// check ends the record on the length result, with length_error and last set. The
// payload then yields one CSI sample result (kind 1) per 16 bits after each group's
// three skipped bits; the final sample carries last. Bytes before the first record
// and after the end of one give no result.
// A fed byte is captured in the input register, where the parse logic works on it, and
// the result it yields is then loaded into the result register.
// Throughput is one byte per cycle while the receiver takes results, as the header and
// bit-buffer state update once per byte; each byte yields at most one result.
// When the receiver stalls, the result register holds its transfer and the input
// register still takes one more byte; bytes that give no result keep flowing.
// Reset clears both registers' valid flags and puts the parser in its idle phase.
module csi_feedback_record_parser_unit #(
	parameter int SUBCARRIERS = 30,
	parameter int MAX_CHAINS  = 3
) (
	input logic        clk,
	input logic        arst_n,
	cfrp_byte_if.sink  feed,
	cfrp_res_if.source result
);
	import cfrp_pkg::*;

	// Width of one chain count once it has passed the range check.
	localparam int CHW = (MAX_CHAINS > 1) ? $clog2(MAX_CHAINS + 1) : 1;

	// Input register.
	logic       v_s1;
	logic [7:0] data_s1;
	logic       first_s1;

	logic [1:0] phase_q;
	logic [1:0] ph_eff;

	hdr_res_t       hres;
	pay_res_t       pres;
	logic [CHW-1:0] rx_w;
	logic [CHW-1:0] tx_w;

	logic produce;
	logic consume;
	logic in_fire;
	logic hdr_step;
	logic pay_step;
	res_t res_d;
	res_t res_q;
	logic res_v_q;

	// A first byte opens a new record whatever phase the previous one reached.
	assign ph_eff   = first_s1 ? PH_HEADER : phase_q;
	assign produce  = (ph_eff == PH_HEADER && hres.emit) ||
		(ph_eff == PH_PAYLOAD && pres.emit);
	// The byte in the input register may move on unless its result would land on a
	// result that the receiver has not yet taken.
	assign consume  = v_s1 && (!res_v_q || result.ready || !produce);
	assign hdr_step = consume && ph_eff == PH_HEADER;
	assign pay_step = consume && ph_eff == PH_PAYLOAD;
	assign in_fire  = feed.valid && feed.ready;
	assign feed.ready = !v_s1 || consume;

	cfrp_hdr #(
		.SUBCARRIERS(SUBCARRIERS),
		.MAX_CHAINS (MAX_CHAINS),
		.CHW        (CHW)
	) u_hdr (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (hdr_step),
		.restart  (first_s1),
		.data_byte(data_s1),
		.res      (hres),
		.rx       (rx_w),
		.tx       (tx_w)
	);

	cfrp_unpack #(
		.SUBCARRIERS(SUBCARRIERS),
		.CHW        (CHW)
	) u_unpack (
		.clk      (clk),
		.arst_n   (arst_n),
		.init     (consume && first_s1),
		.step     (pay_step),
		.data_byte(data_s1),
		.rx       (rx_w),
		.tx       (tx_w),
		.res      (pres)
	);

	// Result assembly; fields that do not belong to the result kind stay zero.
	always_comb begin
		res_d = '0;
		if (ph_eff == PH_HEADER) begin
			res_d.kind         = 1'b0;
			res_d.field_id     = hres.field_id;
			res_d.value        = hres.value;
			res_d.length_error = hres.err;
			res_d.last         = hres.err;
		end else begin
			res_d.kind          = 1'b1;
			res_d.csi_real      = pres.csi_real;
			res_d.csi_imag      = pres.csi_imag;
			res_d.subcarrier    = pres.subcarrier;
			res_d.element_index = pres.element_index;
			res_d.last          = pres.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (consume) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1  <= feed.data_byte;
			first_s1 <= feed.first_byte;
		end
	end

	// Record phase: idle until the first record, done after its final result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (consume) begin
			case (ph_eff)
				PH_HEADER: begin
					if (hres.err) begin
						phase_q <= PH_DONE;
					end else if (hres.done) begin
						phase_q <= PH_PAYLOAD;
					end else begin
						phase_q <= PH_HEADER;
					end
				end
				PH_PAYLOAD: begin
					if (pres.emit && pres.last) begin
						phase_q <= PH_DONE;
					end
				end
				default: phase_q <= ph_eff;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (consume && produce) begin
			res_v_q <= 1'b1;
		end else if (result.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && produce) begin
			res_q <= res_d;
		end
	end

	assign result.valid         = res_v_q;
	assign result.kind          = res_q.kind;
	assign result.field_id      = res_q.field_id;
	assign result.value         = res_q.value;
	assign result.csi_real      = res_q.csi_real;
	assign result.csi_imag      = res_q.csi_imag;
	assign result.subcarrier    = res_q.subcarrier;
	assign result.element_index = res_q.element_index;
	assign result.length_error  = res_q.length_error;
	assign result.last          = res_q.last;

`ifndef SYNTHESIS
	// A produced result always reaches the result register.
	a_res_load: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && produce) |=> res_v_q)
		else $error("produced result was not registered");

	// A finished or failed record gives nothing until the next first byte.
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !first_s1 && (phase_q == PH_DONE || phase_q == PH_IDLE)) |-> !produce)
		else $error("result produced outside a record");

	// A header result only ends a record when the size check failed.
	a_hdr_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && !res_q.kind && res_q.last) |-> res_q.length_error)
		else $error("header result marked last without length error");

	// The input register only holds back for a stalled result register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !feed.ready) |-> (res_v_q && !result.ready))
		else $error("input stalled without output backpressure");
`endif

endmodule
